// ----- rtl/core/unsigned_to_decimal_text_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-width decimal text formatter
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_TEXT_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_TEXT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define U2DT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u2dt assertion failed");
// Next-cycle implication, checked out of reset
`define U2DT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u2dt assertion failed");
`else
`define U2DT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define U2DT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/u2dt_pkg.sv -----
// ----------------------------------------------------------------------------
// u2dt_pkg
// Request and result types and character constants of the decimal formatter.
// ----------------------------------------------------------------------------
package u2dt_pkg;

  localparam int VALUE_W = 16;
  localparam int WIDTH_W = 4;
  localparam int CHAR_W  = 8;
  localparam int BCD_W   = 4;

  // ASCII codes used in the field
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_QUERY = 8'd63;

  // Double-dabble correction: digits at or above the limit get the offset
  localparam logic [BCD_W-1:0] DAB_LIMIT = 4'd5;
  localparam logic [BCD_W-1:0] DAB_ADD   = 4'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0] width;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic              overflow;
  } out_rsp_t;

  // Converter status seen by the top level
  typedef struct packed {
    logic busy;
    logic done;
  } u2dt_stat_t;

endpackage

// ----- rtl/core/u2dt_dabble.sv -----
// ----------------------------------------------------------------------------
// u2dt_dabble
// Bit-serial binary to BCD converter: one value bit shifted in per cycle.
// ----------------------------------------------------------------------------
module u2dt_dabble #(
  parameter int UB     = 16,
  parameter int DIGITS = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [UB-1:0]              value,
  output u2dt_pkg::u2dt_stat_t       stat,
  output logic [DIGITS*u2dt_pkg::BCD_W-1:0] bcd
);
  import u2dt_pkg::*;

  localparam int CW = $clog2(UB + 1);
  localparam int DW = DIGITS * BCD_W;

  logic [UB-1:0] bin_r,  bin_nxt;
  logic [DW-1:0] bcd_r,  bcd_nxt;
  logic [DW-1:0] adj;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*BCD_W +: BCD_W] >= DAB_LIMIT) begin
        adj[i*BCD_W +: BCD_W] = bcd_r[i*BCD_W +: BCD_W] + DAB_ADD;
      end else begin
        adj[i*BCD_W +: BCD_W] = bcd_r[i*BCD_W +: BCD_W];
      end
    end
  end

  // Shift one binary bit into the digit register per cycle
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (load) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = CW'(UB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[DW-2:0], bin_r[UB-1]};
      bin_nxt = {bin_r[UB-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset, payload free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

// ----- rtl/core/u2dt_emit.sv -----
// ----------------------------------------------------------------------------
// u2dt_emit
// Strips leading zero digits, then emits the field one character per cycle.
// ----------------------------------------------------------------------------
module u2dt_emit #(
  parameter int DIGITS = 5,
  parameter int WW     = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [DIGITS*u2dt_pkg::BCD_W-1:0] bcd,
  input  logic [WW-1:0]                     width,
  output logic                              busy,
  output logic                              out_strobe,
  output u2dt_pkg::out_rsp_t                out_rsp
);
  import u2dt_pkg::*;

  localparam int DW    = DIGITS * BCD_W;
  localparam int ND_W  = $clog2(DIGITS + 1);
  localparam int CMP_W = (ND_W > WW) ? ND_W : WW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t        state_r,  state_nxt;
  logic [DW-1:0] bcd_r,    bcd_nxt;
  logic [ND_W-1:0] nd_r,   nd_nxt;
  logic [WW-1:0] w_r,      w_nxt;
  logic [WW-1:0] idx_r,    idx_nxt;
  logic          ovf_r,    ovf_nxt;
  logic          strobe_r, strobe_nxt;
  out_rsp_t      rsp_r,    rsp_nxt;
  logic [BCD_W-1:0] top_digit;

  assign top_digit = bcd_r[DW-1 -: BCD_W];

  // Sequence: scan off leading zeros, then walk the field left to right
  always_comb begin
    state_nxt  = state_r;
    bcd_nxt    = bcd_r;
    nd_nxt     = nd_r;
    w_nxt      = w_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    strobe_nxt = 1'b0;
    rsp_nxt    = rsp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          bcd_nxt   = bcd;
          nd_nxt    = ND_W'(DIGITS);
          w_nxt     = width;
          idx_nxt   = width - 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((top_digit == '0) && (nd_r != ND_W'(1))) begin
          bcd_nxt = {bcd_r[DW-BCD_W-1:0], {BCD_W{1'b0}}};
          nd_nxt  = nd_r - 1'b1;
        end else begin
          ovf_nxt   = CMP_W'(nd_r) > CMP_W'(w_r);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_nxt       = 1'b1;
        rsp_nxt.last     = (idx_r == '0);
        rsp_nxt.overflow = ovf_r;
        if (ovf_r) begin
          rsp_nxt.char_out = CH_QUERY;
        end else if (CMP_W'(idx_r) >= CMP_W'(nd_r)) begin
          rsp_nxt.char_out = CH_SPACE;
        end else begin
          rsp_nxt.char_out = CH_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
          bcd_nxt          = {bcd_r[DW-BCD_W-1:0], {BCD_W{1'b0}}};
        end
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    bcd_r <= bcd_nxt;
    nd_r  <= nd_nxt;
    w_r   <= w_nxt;
    idx_r <= idx_nxt;
    ovf_r <= ovf_nxt;
    rsp_r <= rsp_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

endmodule

// ----- rtl/core/unsigned_to_decimal_text.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_decimal_text
// Formats an unsigned number as a right-justified decimal text field.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_req (value, width) and raise start; the request is taken at the
//   rising edge where start is high and busy is low. busy stays high until
//   the last character of the field is on out_rsp.
//   Each character appears on out_rsp for exactly one cycle with out_strobe
//   high; last marks the rightmost one, overflow marks a field of '?'.
//   The receiver cannot stall: characters must be taken as they come.
// Sequence (U = min(VALUE_BITS, 16), D = decimal digits of U bits, w = width):
//   The serial converter shifts in the U value bits, one value bit per cycle,
//   then hands over to the zero strip, which drops leading zeros one digit per
//   cycle and keeps at least one of the D digits; the field of w characters
//   then follows, one character per cycle. A new request is taken only once
//   busy is low again, so no new value is taken before the last one is out.
//   A width of zero is taken as one, widths beyond MAX_WIDTH are clipped.
// Reset (rst_n low, synchronous) drops any request in progress, clears busy
//   and out_strobe.
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_text_macros.svh"

module unsigned_to_decimal_text #(
  parameter int MAX_WIDTH  = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  u2dt_pkg::in_req_t   in_req,
  output logic                out_strobe,
  output u2dt_pkg::out_rsp_t  out_rsp
);
  import u2dt_pkg::*;

  localparam int UB     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int DIGITS = ((UB * 1233) >> 12) + 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);

  logic            accept;
  logic [WW-1:0]   w_clip;
  logic [WW-1:0]   w_r;
  u2dt_stat_t      dab_stat;
  logic [DIGITS*BCD_W-1:0] dab_bcd;
  logic            emit_busy;

  assign accept = start && !busy;

  // Clip the requested width into 1 .. MAX_WIDTH
  always_comb begin
    if (in_req.width == '0) begin
      w_clip = WW'(1);
    end else if ({1'b0, in_req.width} > (WIDTH_W + 1)'(MAX_WIDTH)) begin
      w_clip = WW'(MAX_WIDTH);
    end else begin
      w_clip = WW'(in_req.width);
    end
  end

  // Hold the field width while the value converts
  always_ff @(posedge clk) begin
    if (accept) begin
      w_r <= w_clip;
    end
  end

  u2dt_dabble #(
    .UB     (UB),
    .DIGITS (DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .value (in_req.value[UB-1:0]),
    .stat  (dab_stat),
    .bcd   (dab_bcd)
  );

  u2dt_emit #(
    .DIGITS (DIGITS),
    .WW     (WW)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (dab_stat.done),
    .bcd        (dab_bcd),
    .width      (w_r),
    .busy       (emit_busy),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  assign busy = dab_stat.busy || dab_stat.done || emit_busy;

  // An accepted request keeps the block busy
  `U2DT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  // The rightmost character closes the field
  `U2DT_ASSERT_NEXT(a_last_ends, clk, rst_n, out_strobe && out_rsp.last, !out_strobe)
  // A character only follows a busy cycle
  `U2DT_ASSERT_IMPL(a_strobe_busy, clk, rst_n, out_strobe, $past(busy))
  // An overflowed field carries only query marks
  `U2DT_ASSERT_IMPL(a_ovf_query, clk, rst_n, out_strobe && out_rsp.overflow, out_rsp.char_out == CH_QUERY)

endmodule
